// File: hw/rtl/lkv_pkg.sv
// lkv_pkg: shared types and constants for the lru key-value cache
// no dependencies; imported by every lkv_* module and the top level
`default_nettype none

package lkv_pkg;

	localparam int DATA_W = 32;
	localparam int CAP_W  = 5;

	// capacity after reset
	localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

	// read value reported on a get miss and on every put
	localparam logic [DATA_W-1:0] MISS_VALUE = {DATA_W{1'b1}};

	typedef enum logic [0:0] {
		OP_GET = 1'b0,
		OP_PUT = 1'b1
	} op_t;

endpackage

`default_nettype wire

// File: hw/rtl/lkv_lookup.sv
// lkv_lookup: parallel key compare, lowest free slot and lru victim search
// depends on lkv_pkg
`default_nettype none

module lkv_lookup
	import lkv_pkg::*;
#(
	parameter int ENTRIES = 16,
	parameter int IDX_W   = 4,
	parameter int OCC_W   = 5
) (
	input  wire logic [ENTRIES-1:0] valid,
	input  wire logic [DATA_W-1:0]  keys [ENTRIES],
	input  wire logic [IDX_W-1:0]   ages [ENTRIES],
	input  wire logic [DATA_W-1:0]  key,
	input  wire logic [OCC_W-1:0]   occupancy,
	output logic                    hit,
	output logic [IDX_W-1:0]        hit_idx,
	output logic                    has_free,
	output logic [IDX_W-1:0]        free_idx,
	output logic [IDX_W-1:0]        victim_idx
);

	logic [IDX_W-1:0] oldest_age;

	// least recent entry carries rank occupancy-1
	assign oldest_age = IDX_W'(occupancy - OCC_W'(1));

	// scan downward so the lowest matching index wins
	always_comb begin
		hit        = 1'b0;
		hit_idx    = '0;
		has_free   = 1'b0;
		free_idx   = '0;
		victim_idx = '0;
		for (int i = ENTRIES - 1; i >= 0; i--) begin
			if (valid[i] && keys[i] == key) begin
				hit     = 1'b1;
				hit_idx = IDX_W'(i);
			end
			if (!valid[i]) begin
				has_free = 1'b1;
				free_idx = IDX_W'(i);
			end
			if (valid[i] && ages[i] == oldest_age) begin
				victim_idx = IDX_W'(i);
			end
		end
	end

endmodule

`default_nettype wire

// File: hw/rtl/lkv_age_update.sv
// lkv_age_update: next recency ranks after a touch or a fill
// depends on lkv_pkg
`default_nettype none

module lkv_age_update
	import lkv_pkg::*;
#(
	parameter int ENTRIES = 16,
	parameter int IDX_W   = 4
) (
	input  wire logic [ENTRIES-1:0] valid,
	input  wire logic [IDX_W-1:0]   ages [ENTRIES],
	input  wire logic [IDX_W-1:0]   touch_idx,
	input  wire logic               fill,
	output logic [IDX_W-1:0]        next_ages [ENTRIES]
);

	logic [IDX_W-1:0] limit;

	assign limit = ages[touch_idx];

	// touched entry becomes most recent, more recent ones age by one;
	// a fill ages every live entry
	always_comb begin
		for (int i = 0; i < ENTRIES; i++) begin
			if (IDX_W'(i) == touch_idx) begin
				next_ages[i] = '0;
			end else if (valid[i] && (fill || ages[i] < limit)) begin
				next_ages[i] = ages[i] + IDX_W'(1);
			end else begin
				next_ages[i] = ages[i];
			end
		end
	end

endmodule

`default_nettype wire

// File: hw/rtl/lru_key_value_cache_unit.sv
// lru_key_value_cache_unit: fully associative key-value cache with lru replacement
// depends on lkv_pkg, lkv_lookup and lkv_age_update
//
// channel   signals                                         direction  transfer
// command   start, busy, opcode, lookup_key, write_value    in         start && !busy
// result    done, hit, read_value, evicted, evicted_key     out        done (one cycle)
// config    cfg_valid, cfg_ready, cfg_data                  in         cfg_valid && cfg_ready
//
// one command per cycle while busy is low; the command register loads at the transfer
// edge and the result register at the next edge, so done is high in the cycle after
// the command register holds the command; cost is set by the parallel key compare
// and the recency-rank update over all entries in the second stage
// arst_n clears valid bits, ranks, occupancy and capacity (to 16)
// the receiver cannot stall; busy is high only in a cycle that takes a config write
`default_nettype none

module lru_key_value_cache_unit
	import lkv_pkg::*;
#(
	parameter int ENTRIES = 16
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	// command
	input  wire logic              start,
	output logic                   busy,
	input  wire logic              opcode,
	input  wire logic [DATA_W-1:0] lookup_key,
	input  wire logic [DATA_W-1:0] write_value,
	// result
	output logic                   done,
	output logic                   hit,
	output logic [DATA_W-1:0]      read_value,
	output logic                   evicted,
	output logic [DATA_W-1:0]      evicted_key,
	// capacity register
	input  wire logic              cfg_valid,
	output logic                   cfg_ready,
	input  wire logic [CAP_W-1:0]  cfg_data
);

	localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam int OCC_W = $clog2(ENTRIES + 1);
	localparam int CNT_W = (OCC_W > CAP_W) ? OCC_W : CAP_W;

	// stored state
	logic [ENTRIES-1:0] valid_q;
	logic [DATA_W-1:0]  key_q   [ENTRIES];
	logic [DATA_W-1:0]  value_q [ENTRIES];
	logic [IDX_W-1:0]   age_q   [ENTRIES];
	logic [OCC_W-1:0]   occupancy_q;
	logic [CAP_W-1:0]   capacity_q;

	// command register
	logic              valid_s1;
	op_t               op_s1;
	logic [DATA_W-1:0] key_s1;
	logic [DATA_W-1:0] wval_s1;

	// result register
	logic              done_q;
	logic              hit_q;
	logic [DATA_W-1:0] read_q;
	logic              evicted_q;
	logic [DATA_W-1:0] evk_q;

	// lookup results
	logic             lk_hit;
	logic [IDX_W-1:0] lk_hit_idx;
	logic             lk_has_free;
	logic [IDX_W-1:0] lk_free_idx;
	logic [IDX_W-1:0] lk_victim_idx;

	logic [IDX_W-1:0] next_age [ENTRIES];

	logic             cfg_write;
	logic             cmd_take;
	logic [CNT_W-1:0] cap_ext;
	logic [CNT_W-1:0] eff_cap;
	logic             full;
	logic             is_put;
	logic             do_touch;
	logic             do_evict;
	logic             do_fill;
	logic             do_write;
	logic [IDX_W-1:0] touch_idx;

	// config writes wait for the command stage to drain
	assign cfg_ready = !valid_s1;
	assign cfg_write = cfg_valid && cfg_ready;
	assign busy      = cfg_write;
	assign cmd_take  = start && !busy;

	// effective capacity: zero acts as one, saturate at the entry count
	always_comb begin
		cap_ext = CNT_W'(capacity_q);
		if (cap_ext == '0) begin
			eff_cap = CNT_W'(1);
		end else if (cap_ext > CNT_W'(ENTRIES)) begin
			eff_cap = CNT_W'(ENTRIES);
		end else begin
			eff_cap = cap_ext;
		end
	end

	assign full   = CNT_W'(occupancy_q) >= eff_cap;
	assign is_put = (op_s1 == OP_PUT);

	lkv_lookup #(
		.ENTRIES (ENTRIES),
		.IDX_W   (IDX_W),
		.OCC_W   (OCC_W)
	) u_lookup (
		.valid      (valid_q),
		.keys       (key_q),
		.ages       (age_q),
		.key        (key_s1),
		.occupancy  (occupancy_q),
		.hit        (lk_hit),
		.hit_idx    (lk_hit_idx),
		.has_free   (lk_has_free),
		.free_idx   (lk_free_idx),
		.victim_idx (lk_victim_idx)
	);

	// what this command does to the store
	assign do_evict = valid_s1 && !lk_hit && is_put && full;
	assign do_fill  = valid_s1 && !lk_hit && is_put && !full && lk_has_free;
	assign do_touch = (valid_s1 && lk_hit) || do_evict || do_fill;
	assign do_write = (valid_s1 && lk_hit && is_put) || do_evict || do_fill;

	// one entry is touched, and on a put written: hit, victim or free slot
	always_comb begin
		if (lk_hit) begin
			touch_idx = lk_hit_idx;
		end else if (full) begin
			touch_idx = lk_victim_idx;
		end else begin
			touch_idx = lk_free_idx;
		end
	end

	lkv_age_update #(
		.ENTRIES (ENTRIES),
		.IDX_W   (IDX_W)
	) u_age (
		.valid     (valid_q),
		.ages      (age_q),
		.touch_idx (touch_idx),
		.fill      (do_fill),
		.next_ages (next_age)
	);

	// command register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= cmd_take;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd_take) begin
			op_s1   <= op_t'(opcode);
			key_s1  <= lookup_key;
			wval_s1 <= write_value;
		end
	end

	// control state: valid bits, ranks, occupancy, capacity
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q     <= '0;
			occupancy_q <= '0;
			capacity_q  <= CAP_RESET;
			for (int i = 0; i < ENTRIES; i++) begin
				age_q[i] <= '0;
			end
		end else if (cfg_write) begin
			// any capacity write empties the cache
			valid_q     <= '0;
			occupancy_q <= '0;
			capacity_q  <= cfg_data;
			for (int i = 0; i < ENTRIES; i++) begin
				age_q[i] <= '0;
			end
		end else begin
			if (do_touch) begin
				age_q <= next_age;
			end
			if (do_fill) begin
				valid_q[lk_free_idx] <= 1'b1;
				occupancy_q          <= occupancy_q + OCC_W'(1);
			end
		end
	end

	// key and value store, single write port
	always_ff @(posedge clk) begin
		if (do_write) begin
			key_q[touch_idx]   <= key_s1;
			value_q[touch_idx] <= wval_s1;
		end
	end

	// result register, read from the store before this command's write
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1) begin
			hit_q     <= lk_hit;
			read_q    <= (lk_hit && !is_put) ? value_q[lk_hit_idx] : MISS_VALUE;
			evicted_q <= do_evict;
			evk_q     <= do_evict ? key_q[lk_victim_idx] : '0;
		end
	end

	assign done        = done_q;
	assign hit         = hit_q;
	assign read_value  = read_q;
	assign evicted     = evicted_q;
	assign evicted_key = evk_q;

endmodule

`default_nettype wire

// File: tb/lru_key_value_cache_unit_tb.sv
// lru_key_value_cache_unit_tb: self-checking testbench for the lru key-value cache
// depends on lkv_pkg and lru_key_value_cache_unit; predicts every result with its own cache copy
`timescale 1ns / 100ps

module lru_key_value_cache_unit_tb;
	import lkv_pkg::*;

	localparam int ENTRIES        = 16;
	localparam int WATCHDOG_LIMIT = 1000;
	localparam int PRINT_LIMIT    = 100;
	localparam int PHASE_ITEMS    = 70;

	// one expected result as it should appear on the result ports
	typedef struct {
		logic              hit;
		logic [DATA_W-1:0] read_value;
		logic              evicted;
		logic [DATA_W-1:0] evicted_key;
	} cache_result_t;

	logic              clk;
	logic              arst_n;
	logic              start;
	logic              busy;
	logic              opcode;
	logic [DATA_W-1:0] lookup_key;
	logic [DATA_W-1:0] write_value;
	logic              done;
	logic              hit;
	logic [DATA_W-1:0] read_value;
	logic              evicted;
	logic [DATA_W-1:0] evicted_key;
	logic              cfg_valid;
	logic              cfg_ready;
	logic [CAP_W-1:0]  cfg_data;

	// predictor copy of the cache contents
	logic              slot_live [ENTRIES];
	logic [DATA_W-1:0] slot_key  [ENTRIES];
	logic [DATA_W-1:0] slot_data [ENTRIES];
	logic [3:0]        slot_rank [ENTRIES];
	int                fill_count;
	logic [CAP_W-1:0]  cap_setting;

	cache_result_t     expected_results[$];
	int                mismatch_count;
	int                quiet_cycles;
	bit                gaps_on;

	lru_key_value_cache_unit #(
		.ENTRIES(ENTRIES)
	) dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.busy       (busy),
		.opcode     (opcode),
		.lookup_key (lookup_key),
		.write_value(write_value),
		.done       (done),
		.hit        (hit),
		.read_value (read_value),
		.evicted    (evicted),
		.evicted_key(evicted_key),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_data   (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// ---------------------------------------------------------------
	// predictor
	// ---------------------------------------------------------------

	// every capacity write, and reset, leaves an empty cache
	function automatic void empty_cache(input logic [CAP_W-1:0] cap);
		for (int i = 0; i < ENTRIES; i++) begin
			slot_live[i] = 1'b0;
			slot_key[i]  = '0;
			slot_data[i] = '0;
			slot_rank[i] = '0;
		end
		fill_count  = 0;
		cap_setting = cap;
	endfunction

	// zero acts as one, anything past the table size is clamped
	function automatic int effective_capacity(input logic [CAP_W-1:0] cap);
		if (cap == 0)
			return 1;
		if (cap > ENTRIES)
			return ENTRIES;
		return int'(cap);
	endfunction

	// make a slot most recent; the ones that were more recent slide down a rank
	function automatic void promote_slot(input int idx);
		logic [3:0] prior;
		prior = slot_rank[idx];
		for (int i = 0; i < ENTRIES; i++)
			if (slot_live[i] && i != idx && slot_rank[i] < prior)
				slot_rank[i]++;
		slot_rank[idx] = '0;
	endfunction

	function automatic cache_result_t cache_access(input op_t op, input logic [DATA_W-1:0] key,
			input logic [DATA_W-1:0] data);
		cache_result_t res;
		int            found;
		int            slot;
		logic [3:0]    oldest;
		res.hit         = 1'b0;
		res.read_value  = MISS_VALUE;
		res.evicted     = 1'b0;
		res.evicted_key = '0;
		found = -1;
		slot  = -1;
		for (int i = 0; i < ENTRIES; i++)
			if (found < 0 && slot_live[i] && slot_key[i] == key)
				found = i;
		if (found >= 0) begin
			res.hit = 1'b1;
			if (op == OP_GET)
				res.read_value = slot_data[found];
			else
				slot_data[found] = data;
			promote_slot(found);
		end else if (op == OP_PUT) begin
			if (fill_count >= effective_capacity(cap_setting)) begin
				// full: replace the least recently used slot
				oldest = '0;
				for (int i = 0; i < ENTRIES; i++)
					if (slot_live[i] && (slot < 0 || slot_rank[i] > oldest)) begin
						slot   = i;
						oldest = slot_rank[i];
					end
				if (slot >= 0) begin
					res.evicted     = 1'b1;
					res.evicted_key = slot_key[slot];
					slot_key[slot]  = key;
					slot_data[slot] = data;
					promote_slot(slot);
				end
			end else begin
				// room left: lowest free slot, everybody else ages
				for (int i = 0; i < ENTRIES; i++)
					if (slot < 0 && !slot_live[i])
						slot = i;
				if (slot >= 0) begin
					for (int i = 0; i < ENTRIES; i++)
						if (slot_live[i])
							slot_rank[i]++;
					slot_live[slot] = 1'b1;
					slot_key[slot]  = key;
					slot_data[slot] = data;
					slot_rank[slot] = '0;
					fill_count++;
				end
			end
		end
		return res;
	endfunction

	// ---------------------------------------------------------------
	// shared drivers
	// ---------------------------------------------------------------

	task automatic report_mismatch(input string what);
		// quiet after the first hundred, still counted
		if (mismatch_count < PRINT_LIMIT)
			$display("mismatch at %0t: %s", $time, what);
		mismatch_count++;
	endtask

	// random idle cycles on the sending side, about 11 in a hundred
	task automatic idle_gap();
		while (gaps_on && $urandom_range(0, 99) < 11) begin
			start <= 1'b0;
			@(negedge clk);
		end
	endtask

	// one command transfer; start stays high so back-to-back commands need no gap
	task automatic issue_command(input op_t op, input logic [DATA_W-1:0] key,
			input logic [DATA_W-1:0] data);
		idle_gap();
		start       <= 1'b1;
		opcode      <= op;
		lookup_key  <= key;
		write_value <= data;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		expected_results.push_back(cache_access(op, key, data));
		@(negedge clk);
	endtask

	// lower start and hold until every outstanding result has come back
	task automatic wait_results_drained();
		start <= 1'b0;
		do
			@(negedge clk);
		while (expected_results.size() != 0);
	endtask

	// capacity transfer, only with the cache idle
	task automatic write_capacity(input logic [CAP_W-1:0] cap);
		wait_results_drained();
		idle_gap();
		cfg_valid <= 1'b1;
		cfg_data  <= cap;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		empty_cache(cap);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// ---------------------------------------------------------------
	// result checking: the receiver never stalls, every done is one transfer
	// ---------------------------------------------------------------
	always @(posedge clk) begin : result_checker
		cache_result_t want;
		if (arst_n && done) begin
			if (expected_results.size() == 0) begin
				report_mismatch("result transfer with no command outstanding");
			end else begin
				want = expected_results.pop_front();
				if (hit !== want.hit)
					report_mismatch($sformatf("hit got %b want %b", hit, want.hit));
				if (read_value !== want.read_value)
					report_mismatch($sformatf("read_value got %h want %h",
						read_value, want.read_value));
				if (evicted !== want.evicted)
					report_mismatch($sformatf("evicted got %b want %b",
						evicted, want.evicted));
				if (evicted_key !== want.evicted_key)
					report_mismatch($sformatf("evicted_key got %h want %h",
						evicted_key, want.evicted_key));
			end
		end
	end

	// watchdog: ends the run after too many cycles without any transfer
	initial begin : watchdog
		quiet_cycles = 0;
		while (quiet_cycles < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if ((start && !busy) || done || (cfg_valid && cfg_ready))
				quiet_cycles = 0;
			else
				quiet_cycles++;
		end
		$display("timeout after %0d cycles with no transfer", WATCHDOG_LIMIT);
		$display("lru_key_value_cache_unit_tb NOT OK");
		$finish;
	end

	// ---------------------------------------------------------------
	// tests
	// ---------------------------------------------------------------

	// reset capacity: extreme keys and values, get miss on empty, put update,
	// get ignoring its write value, an all-ones value that still hits
	task automatic test_get_put_extremes();
		issue_command(OP_GET, 32'h0000_0000, 32'h0000_0000);
		issue_command(OP_PUT, 32'h8000_0000, 32'h7fff_ffff);
		issue_command(OP_PUT, 32'h7fff_ffff, 32'h8000_0000);
		issue_command(OP_PUT, 32'h0000_0000, 32'h0000_0000);
		issue_command(OP_PUT, 32'hffff_ffff, 32'hffff_ffff);
		issue_command(OP_GET, 32'h8000_0000, 32'h0000_0000);
		issue_command(OP_GET, 32'hffff_ffff, 32'h0000_0000);
		issue_command(OP_PUT, 32'h0000_0000, 32'h5a5a_5a5a);
		issue_command(OP_GET, 32'h0000_0000, 32'hdead_beef);
		issue_command(OP_GET, 32'h1234_5678, 32'hffff_ffff);
	endtask

	// capacity one, then zero which acts as one: every new key evicts the old one
	task automatic test_tiny_capacity();
		write_capacity(5'd1);
		issue_command(OP_PUT, 32'h0000_0011, 32'h0000_00a1);
		issue_command(OP_PUT, 32'h0000_0022, 32'h0000_00a2);
		issue_command(OP_GET, 32'h0000_0011, 32'h0000_0000);
		issue_command(OP_GET, 32'h0000_0022, 32'h0000_0000);
		write_capacity(5'd0);
		issue_command(OP_PUT, 32'h0000_000a, 32'h1111_1111);
		issue_command(OP_PUT, 32'h0000_000b, 32'h2222_2222);
		issue_command(OP_GET, 32'h0000_000b, 32'h0000_0000);
	endtask

	// rewriting the same capacity still empties the cache; a get refreshes recency
	task automatic test_capacity_rewrite();
		write_capacity(5'd16);
		issue_command(OP_PUT, 32'h0000_0033, 32'hcafe_f00d);
		write_capacity(5'd16);
		issue_command(OP_GET, 32'h0000_0033, 32'h0000_0000);
		write_capacity(5'd2);
		issue_command(OP_PUT, 32'h0000_00a0, 32'h0000_0001);
		issue_command(OP_PUT, 32'h0000_00b0, 32'h0000_0002);
		issue_command(OP_GET, 32'h0000_00a0, 32'h0000_0000);
		// b0 is now least recent and must be the one evicted
		issue_command(OP_PUT, 32'h0000_00c0, 32'h0000_0003);
	endtask

	// phases at several capacities; keys mostly from a pool a little larger
	// than the capacity so hits, refreshes and evictions all stay frequent
	task automatic test_random_traffic();
		logic [CAP_W-1:0]  caps [10] = '{5'd16, 5'd1, 5'd31, 5'd0, 5'd5,
			5'd17, 5'd2, 5'd8, 5'd15, 5'd3};
		logic [DATA_W-1:0] key_pool[$];
		logic [DATA_W-1:0] key;
		int                pool_size;
		op_t               op;
		caps[9] = CAP_W'($urandom_range(0, 31));
		for (int p = 0; p < 10; p++) begin
			write_capacity(caps[p]);
			key_pool.delete();
			pool_size = effective_capacity(caps[p]) + $urandom_range(1, 4);
			for (int k = 0; k < pool_size; k++)
				key_pool.push_back($urandom());
			// a few sign and bit extremes in the first phases
			if (p < 3) begin
				key_pool[0] = 32'h8000_0000;
				key_pool[pool_size - 1] = 32'hffff_ffff;
			end
			// one long stretch with the sender never idling
			gaps_on = (p != 5);
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				// halfway through one phase the sender waits for all results
				if (p == 3 && n == PHASE_ITEMS / 2)
					wait_results_drained();
				if ($urandom_range(0, 99) < 88)
					key = key_pool[$urandom_range(0, pool_size - 1)];
				else
					key = $urandom();
				op = $urandom_range(0, 1) ? OP_PUT : OP_GET;
				issue_command(op, key, $urandom());
			end
		end
		gaps_on = 1'b1;
	endtask

	// ---------------------------------------------------------------
	// main sequence
	// ---------------------------------------------------------------
	initial begin : stimulus
		arst_n      <= 1'b0;
		start       <= 1'b0;
		opcode      <= OP_GET;
		lookup_key  <= '0;
		write_value <= '0;
		cfg_valid   <= 1'b0;
		cfg_data    <= '0;
		gaps_on        = 1'b1;
		mismatch_count = 0;
		empty_cache(CAP_RESET);
		repeat (11) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		test_get_put_extremes();
		test_tiny_capacity();
		test_capacity_rewrite();
		test_random_traffic();

		// let stray results show up after the last expected one
		wait_results_drained();
		repeat (8) @(negedge clk);
		if (mismatch_count == 0)
			$display("lru_key_value_cache_unit_tb OK");
		else
			$display("lru_key_value_cache_unit_tb NOT OK");
		$finish;
	end

endmodule
